// File: rtl/core/srwc_pkg.sv
// package: types, codes and constants of the selective-repeat window controller
`timescale 1ns / 1ps
`default_nettype none
package srwc_pkg;

  localparam int WINDOW_DEF       = 16;
  localparam int SEQ_MAX_DEF      = 31;
  localparam int PAYLOAD_BITS_DEF = 64;

  localparam int OP_W    = 3;
  localparam int KIND_W  = 2;
  localparam int SEQ_W   = 5;
  localparam int TICKS_W = 16;
  localparam int CFG_IDX_W = 1;

  localparam logic [TICKS_W-1:0] DATA_TICKS_RST = 16'd2500;
  localparam logic [TICKS_W-1:0] ACK_TICKS_RST  = 16'd1200;

  typedef enum logic [OP_W-1:0] {
    OP_PACKET   = 3'd0,
    OP_LINK     = 3'd1,
    OP_FRAME    = 3'd2,
    OP_DATA_TO  = 3'd3,
    OP_ACK_TO   = 3'd4
  } op_t;

  localparam logic [KIND_W-1:0] KIND_DATA = 2'd0;
  localparam logic [KIND_W-1:0] KIND_NAK  = 2'd2;

  typedef enum logic [2:0] {
    ACT_SEND_DATA = 3'd0,
    ACT_SEND_ACK  = 3'd1,
    ACT_SEND_NAK  = 3'd2,
    ACT_DELIVER   = 3'd3,
    ACT_STOP      = 3'd4,
    ACT_STATUS    = 3'd5
  } act_t;

  localparam logic [CFG_IDX_W-1:0] REG_DATA_TICKS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ACK_TICKS  = 1'd1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_STORE,
    ST_RD_SEND,
    ST_EMIT_SEND,
    ST_FRAME_DATA,
    ST_DLV_CHECK,
    ST_DLV_READ,
    ST_DLV_EMIT,
    ST_NAK_CHECK,
    ST_ACK_LOOP,
    ST_EMIT,
    ST_STATUS
  } state_t;

endpackage
`default_nettype wire

// File: rtl/core/srwc_if.sv
// interfaces: request and result channels
`timescale 1ns / 1ps
`default_nettype none
interface srwc_in_if #(
  parameter int PAYLOAD_BITS = 64
);
  logic                    valid;
  logic                    ready;
  logic [2:0]              operation;
  logic                    frame_good;
  logic [1:0]              frame_kind;
  logic [4:0]              frame_seq;
  logic [4:0]              rx_ack;
  logic [PAYLOAD_BITS-1:0] payload_word;

  modport source (output valid, operation, frame_good, frame_kind, frame_seq, rx_ack,
                  payload_word, input ready);
  modport sink (input valid, operation, frame_good, frame_kind, frame_seq, rx_ack,
                payload_word, output ready);
endinterface

interface srwc_out_if #(
  parameter int PAYLOAD_BITS = 64
);
  logic                    valid;
  logic                    ready;
  logic [2:0]              action;
  logic [4:0]              seq_out;
  logic [4:0]              ack_out;
  logic [PAYLOAD_BITS-1:0] payload_out;
  logic [15:0]             timer_ticks;
  logic                    network_enable;
  logic                    last;

  modport source (output valid, action, seq_out, ack_out, payload_out, timer_ticks,
                  network_enable, last, input ready);
  modport sink (input valid, action, seq_out, ack_out, payload_out, timer_ticks,
                network_enable, last, output ready);
endinterface
`default_nettype wire

// File: rtl/core/srwc_ram.sv
// generic single-port ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module srwc_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // write, and registered read of the addressed word (the old word on a write)
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

// File: rtl/core/selective_repeat_window_controller.sv
// top level: selective-repeat arq window controller
//
//  channel | dir | signals
//  req     | in  | operation, frame_good, frame_kind, frame_seq, rx_ack, payload_word
//  res     | out | action, seq_out, ack_out, payload_out, timer_ticks, network_enable, last
//  cfg     | in  | cfg_we, cfg_index, cfg_data
//
// one request at a time; a small sequencer walks the windows with narrow
// modulo-seq adders and compares and one ram port per store. each delivered
// frame and each acked frame lengthens a request, as does a result held by a
// stalled sink; the next request is taken only once the status result has left.
// reset is synchronous and clears all control state; the stores hold no reset
// value.
`timescale 1ns / 1ps
`default_nettype none
module selective_repeat_window_controller
  import srwc_pkg::*;
#(
  parameter int WINDOW       = WINDOW_DEF,
  parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [TICKS_W-1:0]   cfg_data,
  srwc_in_if.sink                   req,
  srwc_out_if.source                res
);
  localparam int SEQ_MAX = SEQ_MAX_DEF;
  localparam int WI_W = $clog2(WINDOW);
  localparam int SW   = $clog2(SEQ_MAX + 1);
  localparam int CW   = $clog2(WINDOW + 1);
  localparam logic [SW:0] NSEQ = (SW+1)'(SEQ_MAX + 1);

  state_t state, state_next;

  logic [TICKS_W-1:0] data_ticks, ack_ticks;
  logic [SW-1:0] send_next, send_oldest, recv_low, recv_high;
  logic [CW-1:0] outstanding;
  logic          link_ready, nak_pending;
  logic [WINDOW-1:0] slot_arrived;

  // latched request
  logic [OP_W-1:0]         op;
  logic                    good;
  logic [KIND_W-1:0]       kind;
  logic [SW-1:0]           fseq, fack;
  logic [PAYLOAD_BITS-1:0] word;

  // shared modulo arithmetic
  function automatic logic [SW-1:0] seq_inc(input logic [SW-1:0] a);
    logic [SW:0] s;
    s = {1'b0, a} + (SW+1)'(1);
    return (s >= NSEQ) ? SW'(s - NSEQ) : SW'(s);
  endfunction

  function automatic logic [SW-1:0] seq_dist(input logic [SW-1:0] f, input logic [SW-1:0] t);
    logic [SW:0] d;
    d = {1'b0, t} + NSEQ - {1'b0, f};
    return (d >= NSEQ) ? SW'(d - NSEQ) : SW'(d);
  endfunction

  function automatic logic [SW-1:0] seq_red(input logic [4:0] v);
    logic [5:0] r;
    r = {1'b0, v};
    if (r >= 6'(SEQ_MAX + 1)) r = r - 6'(SEQ_MAX + 1);
    return SW'(r);
  endfunction

  function automatic logic [WI_W-1:0] slot(input logic [SW-1:0] s);
    return WI_W'(s % WINDOW);
  endfunction

  // held result
  logic                    ovalid;
  logic [2:0]              o_act;
  logic [SW-1:0]           o_seq, o_ack;
  logic [PAYLOAD_BITS-1:0] o_pay;
  logic [TICKS_W-1:0]      o_ticks;
  logic                    o_en, o_last;
  state_t                  ret_state;

  logic [SW-1:0] ack_now;
  assign ack_now = seq_dist(SW'(1), recv_low);

  // rams
  logic                    s_we, r_we;
  logic [WI_W-1:0]         s_addr, r_addr;
  logic [PAYLOAD_BITS-1:0] s_rd, r_rd;
  logic [SW-1:0]           send_seq;

  srwc_ram #(.WIDTH(PAYLOAD_BITS), .DEPTH(WINDOW)) u_send (
    .clk, .we(s_we), .addr(s_addr), .wdata(word), .rdata(s_rd));
  srwc_ram #(.WIDTH(PAYLOAD_BITS), .DEPTH(WINDOW)) u_recv (
    .clk, .we(r_we), .addr(r_addr), .wdata(word), .rdata(r_rd));

  logic in_win, ack_hit, nak_hit;
  logic [SW-1:0] fack1;
  assign fack1   = seq_inc(fack);
  assign in_win  = seq_dist(recv_low, fseq) <= seq_dist(recv_low, recv_high);
  assign ack_hit = seq_dist(send_oldest, fack) < seq_dist(send_oldest, send_next);
  assign nak_hit = seq_dist(send_oldest, fack1) < seq_dist(send_oldest, send_next);

  logic out_free, req_take, emit_now;
  assign out_free  = !ovalid || res.ready;
  // the status result must have left before a new request is taken
  assign req.ready = (state == ST_IDLE) && !ovalid;
  assign req_take  = req.valid && req.ready;
  assign emit_now  = out_free && ((state == ST_DLV_EMIT) || (state == ST_EMIT) ||
                                  (state == ST_STATUS) || (state == ST_ACK_LOOP && ack_hit));

  assign res.valid          = ovalid;
  assign res.action         = o_act;
  assign res.seq_out        = 5'(o_seq);
  assign res.ack_out        = 5'(o_ack);
  assign res.payload_out    = o_pay;
  assign res.timer_ticks    = o_ticks;
  assign res.network_enable = o_en;
  assign res.last           = o_last;

  // ram addressing
  always_comb begin
    s_we   = (state == ST_STORE);
    s_addr = (state == ST_STORE) ? slot(send_next) : slot(send_seq);
    r_we   = (state == ST_FRAME_DATA) && in_win && !slot_arrived[slot(fseq)];
    r_addr = (state == ST_FRAME_DATA) ? slot(fseq) : slot(recv_low);
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:      if (req_take) state_next = ST_DECODE;
      ST_DECODE: begin
        unique case (op)
          OP_PACKET:  state_next = (outstanding < CW'(WINDOW)) ? ST_STORE : ST_STATUS;
          OP_DATA_TO: state_next = ST_RD_SEND;
          OP_ACK_TO:  state_next = ST_EMIT;
          OP_FRAME: begin
            if (!good || (kind == KIND_DATA && fseq != recv_low))
              state_next = nak_pending ? (good ? ST_FRAME_DATA : ST_STATUS) : ST_EMIT;
            else if (kind == KIND_DATA) state_next = ST_FRAME_DATA;
            else state_next = ST_NAK_CHECK;
          end
          default:    state_next = ST_STATUS;
        endcase
      end
      ST_STORE:     state_next = ST_RD_SEND;
      ST_RD_SEND:   state_next = ST_EMIT_SEND;
      ST_EMIT_SEND: if (out_free) state_next = ST_EMIT;
      ST_FRAME_DATA: state_next = (kind == KIND_DATA && in_win && !slot_arrived[slot(fseq)])
                                  ? ST_DLV_CHECK : ST_NAK_CHECK;
      ST_DLV_CHECK: state_next = slot_arrived[slot(recv_low)] ? ST_DLV_READ : ST_NAK_CHECK;
      ST_DLV_READ:  state_next = ST_DLV_EMIT;
      ST_DLV_EMIT:  if (out_free) state_next = ST_DLV_CHECK;
      ST_NAK_CHECK: state_next = (kind == KIND_NAK && nak_hit) ? ST_RD_SEND : ST_ACK_LOOP;
      ST_ACK_LOOP:  if (out_free) state_next = ack_hit ? ST_ACK_LOOP : ST_STATUS;
      ST_EMIT:      if (out_free) state_next = ret_state;
      ST_STATUS:    if (out_free) state_next = ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
  end

  // state and datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      data_ticks   <= DATA_TICKS_RST;
      ack_ticks    <= ACK_TICKS_RST;
      send_next    <= '0;
      send_oldest  <= '0;
      recv_low     <= '0;
      recv_high    <= SW'((WINDOW - 1) % (SEQ_MAX + 1));
      outstanding  <= '0;
      link_ready   <= 1'b0;
      nak_pending  <= 1'b0;
      slot_arrived <= '0;
      ovalid       <= 1'b0;
      ret_state    <= ST_STATUS;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_DATA_TICKS: data_ticks <= cfg_data;
          REG_ACK_TICKS:  ack_ticks  <= cfg_data;
          default: ;
        endcase
      end

      // result valid: raised when a result is loaded, dropped once taken
      if (emit_now) ovalid <= 1'b1;
      else if (res.ready) ovalid <= 1'b0;

      unique case (state)
        ST_IDLE: if (req_take) begin
          op   <= req.operation;
          good <= req.frame_good;
          kind <= req.frame_kind;
          fseq <= seq_red(req.frame_seq);
          fack <= seq_red(req.rx_ack);
          word <= req.payload_word;
        end
        ST_DECODE: begin
          send_seq <= send_oldest;
          unique case (op)
            OP_LINK:  link_ready <= 1'b1;
            OP_ACK_TO: begin
              o_act <= ACT_SEND_ACK; o_seq <= '0; o_ack <= ack_now; o_pay <= '0;
              o_ticks <= '0; ret_state <= ST_STATUS;
              link_ready <= 1'b0;
            end
            OP_FRAME: if (!nak_pending &&
                          (!good || (kind == KIND_DATA && fseq != recv_low))) begin
              nak_pending <= 1'b1;
              link_ready  <= 1'b0;
              o_act <= ACT_SEND_NAK; o_seq <= '0; o_ack <= ack_now; o_pay <= '0;
              o_ticks <= '0;
              ret_state <= good ? ST_FRAME_DATA : ST_STATUS;
            end
            default: ;
          endcase
        end
        ST_STORE: begin
          send_seq    <= send_next;
          outstanding <= outstanding + CW'(1);
          send_next   <= seq_inc(send_next);
        end
        ST_EMIT_SEND: if (out_free) begin
          o_act <= ACT_SEND_DATA; o_seq <= send_seq; o_ack <= ack_now; o_pay <= s_rd;
          o_ticks <= data_ticks;
          ret_state <= (op == OP_FRAME) ? ST_ACK_LOOP : ST_STATUS;
          link_ready <= 1'b0;
        end
        ST_FRAME_DATA: if (r_we) slot_arrived[slot(fseq)] <= 1'b1;
        ST_DLV_EMIT: if (out_free) begin
          o_act <= ACT_DELIVER; o_seq <= '0; o_ack <= '0; o_pay <= r_rd;
          o_ticks <= ack_ticks; o_en <= 1'b0; o_last <= 1'b0;
          nak_pending <= 1'b0;
          slot_arrived[slot(recv_low)] <= 1'b0;
          recv_low  <= seq_inc(recv_low);
          recv_high <= seq_inc(recv_high);
        end
        ST_NAK_CHECK: send_seq <= fack1;
        ST_ACK_LOOP: if (out_free && ack_hit) begin
          o_act <= ACT_STOP; o_seq <= send_oldest; o_ack <= '0; o_pay <= '0;
          o_ticks <= '0; o_en <= 1'b0; o_last <= 1'b0;
          if (outstanding != '0) outstanding <= outstanding - CW'(1);
          send_oldest <= seq_inc(send_oldest);
        end
        ST_EMIT: if (out_free) begin
          o_en <= 1'b0; o_last <= 1'b0;
        end
        ST_STATUS: if (out_free) begin
          o_act <= ACT_STATUS; o_seq <= '0; o_ack <= '0; o_pay <= '0; o_ticks <= '0;
          o_en <= (outstanding < CW'(WINDOW)) && link_ready; o_last <= 1'b1;
        end
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire
